### design/ptrpc_pkg.sv
`timescale 1ns / 1ps
package ptrpc_pkg;

   localparam int unsigned WaitWidth = 24;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [15:0] StsReaderResp  = 16'h4000;
   localparam logic [15:0] StsPunchResp   = 16'h1000;
   localparam logic [15:0] StsReaderBusy  = 16'h0800;
   localparam logic [15:0] StsReaderNotRdy = 16'h0400;
   localparam logic [15:0] StsPunchBusy   = 16'h0200;
   localparam logic [15:0] StsPunchNotRdy = 16'h0100;

   localparam logic [WaitWidth-1:0] WaitResetValue = 24'd1000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_READER_WAIT = 1'b0,
      CSR_PUNCH_WAIT  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_READ        = 4'd0,
      MODE_PUNCH       = 4'd1,
      MODE_SENSE       = 4'd2,
      MODE_START_READ  = 4'd3,
      MODE_TICK        = 4'd4,
      MODE_ATTACH_RDR  = 4'd5,
      MODE_DETACH_RDR  = 4'd6,
      MODE_ATTACH_PUN  = 4'd7,
      MODE_DETACH_PUN  = 4'd8,
      MODE_RESET_RDR   = 4'd9,
      MODE_RESET_PUN   = 4'd10
   } mode_type;

   typedef struct packed {
      logic        reader_resp;
      logic        punch_resp;
      logic        reader_busy;
      logic        reader_not_ready;
      logic        punch_busy;
      logic        punch_not_ready;
   } flags_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] write_word;
      logic        modifier;
      logic [7:0]  tape_byte;
      logic        tape_more;
      logic        reader_online;
      logic        punch_online;
   } cmd_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] status_word;
      logic        punch_strobe;
      logic [7:0]  punch_byte;
      logic        tape_take;
      logic        interrupt_request;
      logic        bad_function;
   } rsp_type;

   function automatic logic [15:0] status_expand(input flags_type f);
      logic [15:0] w;
      w = '0;
      if (f.reader_resp)      w = w | StsReaderResp;
      if (f.punch_resp)       w = w | StsPunchResp;
      if (f.reader_busy)      w = w | StsReaderBusy;
      if (f.reader_not_ready) w = w | StsReaderNotRdy;
      if (f.punch_busy)       w = w | StsPunchBusy;
      if (f.punch_not_ready)  w = w | StsPunchNotRdy;
      return w;
   endfunction

endpackage

### design/ptrpc_exec.sv
`timescale 1ns / 1ps
module ptrpc_exec (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  ptrpc_pkg::cmd_type                   cmd,
   input  logic                                 csr_we,
   input  logic [ptrpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [ptrpc_pkg::WaitWidth-1:0]      csr_wdata,
   output ptrpc_pkg::rsp_type                   rsp
);

   ptrpc_pkg::flags_type               flags_ff, flags_in;
   logic [7:0]                         last_char_ff, last_char_in;
   logic [ptrpc_pkg::WaitWidth-1:0]    rdr_cnt_ff, rdr_cnt_in;
   logic [ptrpc_pkg::WaitWidth-1:0]    pun_cnt_ff, pun_cnt_in;
   logic                               rdr_pend_ff, rdr_pend_in;
   logic                               pun_pend_ff, pun_pend_in;
   logic                               irq_ff, irq_in;
   logic [ptrpc_pkg::WaitWidth-1:0]    rdr_wait_ff, pun_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rdr_wait_ff <= ptrpc_pkg::WaitResetValue;
         pun_wait_ff <= ptrpc_pkg::WaitResetValue;
      end else if (csr_we) begin
         unique case (ptrpc_pkg::csr_index_type'(csr_index))
            ptrpc_pkg::CSR_READER_WAIT: rdr_wait_ff <= csr_wdata;
            ptrpc_pkg::CSR_PUNCH_WAIT:  pun_wait_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         last_char_ff <= '0;
         rdr_cnt_ff   <= '0;
         pun_cnt_ff   <= '0;
         rdr_pend_ff  <= 1'b0;
         pun_pend_ff  <= 1'b0;
         irq_ff       <= 1'b0;
      end else if (fire) begin
         flags_ff     <= flags_in;
         last_char_ff <= last_char_in;
         rdr_cnt_ff   <= rdr_cnt_in;
         pun_cnt_ff   <= pun_cnt_in;
         rdr_pend_ff  <= rdr_pend_in;
         pun_pend_ff  <= pun_pend_in;
         irq_ff       <= irq_in;
      end
   end

   always_comb begin
      flags_in     = flags_ff;
      last_char_in = last_char_ff;
      rdr_cnt_in   = rdr_cnt_ff;
      pun_cnt_in   = pun_cnt_ff;
      rdr_pend_in  = rdr_pend_ff;
      pun_pend_in  = pun_pend_ff;
      irq_in       = irq_ff;
      rsp          = '0;
      unique case (ptrpc_pkg::mode_type'(cmd.mode))
         ptrpc_pkg::MODE_READ: begin
            rsp.read_data = {last_char_ff, 8'h00};
         end
         ptrpc_pkg::MODE_PUNCH: begin
            if (!flags_ff.punch_not_ready && cmd.punch_online) begin
               rsp.punch_strobe = 1'b1;
               rsp.punch_byte   = cmd.write_word[15:8];
            end
            if (!pun_pend_ff) begin
               pun_pend_in = 1'b1;
               pun_cnt_in  = pun_wait_ff;
            end
            flags_in.punch_not_ready = 1'b1;
            flags_in.punch_busy      = 1'b1;
         end
         ptrpc_pkg::MODE_SENSE: begin
            rsp.status_word = ptrpc_pkg::status_expand(flags_ff);
            if (cmd.modifier) begin
               flags_in.reader_resp = 1'b0;
               flags_in.punch_resp  = 1'b0;
               irq_in               = 1'b0;
            end
         end
         ptrpc_pkg::MODE_START_READ: begin
            if (!rdr_pend_ff) begin
               rdr_pend_in = 1'b1;
               rdr_cnt_in  = rdr_wait_ff;
            end
            flags_in.reader_busy      = 1'b1;
            flags_in.reader_not_ready = 1'b1;
         end
         ptrpc_pkg::MODE_TICK: begin
            if (rdr_pend_ff) begin
               if (rdr_cnt_ff[ptrpc_pkg::WaitWidth-1:1] == '0) begin
                  rdr_pend_in               = 1'b0;
                  rdr_cnt_in                = '0;
                  flags_in.reader_busy      = 1'b0;
                  flags_in.reader_not_ready = 1'b1;
                  if (cmd.reader_online) begin
                     last_char_in  = cmd.tape_byte;
                     rsp.tape_take = 1'b1;
                     if (cmd.tape_more) flags_in.reader_not_ready = 1'b0;
                  end
                  flags_in.reader_resp = 1'b1;
                  irq_in               = 1'b1;
               end else begin
                  rdr_cnt_in = rdr_cnt_ff - ptrpc_pkg::WaitWidth'(1);
               end
            end
            if (pun_pend_ff) begin
               if (pun_cnt_ff[ptrpc_pkg::WaitWidth-1:1] == '0) begin
                  pun_pend_in              = 1'b0;
                  pun_cnt_in               = '0;
                  flags_in.punch_busy      = 1'b0;
                  flags_in.punch_not_ready = !cmd.punch_online;
                  flags_in.punch_resp      = 1'b1;
                  irq_in                   = 1'b1;
               end else begin
                  pun_cnt_in = pun_cnt_ff - ptrpc_pkg::WaitWidth'(1);
               end
            end
         end
         ptrpc_pkg::MODE_ATTACH_RDR: begin
            flags_in.reader_not_ready = !(!flags_ff.reader_busy && cmd.tape_more);
         end
         ptrpc_pkg::MODE_DETACH_RDR: begin
            flags_in.reader_not_ready = 1'b1;
         end
         ptrpc_pkg::MODE_ATTACH_PUN: begin
            flags_in.punch_not_ready = flags_ff.punch_busy;
         end
         ptrpc_pkg::MODE_DETACH_PUN: begin
            flags_in.punch_not_ready = 1'b1;
         end
         ptrpc_pkg::MODE_RESET_RDR: begin
            rdr_pend_in               = 1'b0;
            rdr_cnt_in                = '0;
            flags_in.reader_busy      = 1'b0;
            flags_in.reader_resp      = 1'b0;
            flags_in.reader_not_ready = !(cmd.reader_online && cmd.tape_more);
            if (!flags_ff.punch_resp) irq_in = 1'b0;
         end
         ptrpc_pkg::MODE_RESET_PUN: begin
            pun_pend_in              = 1'b0;
            pun_cnt_in               = '0;
            flags_in.punch_busy      = 1'b0;
            flags_in.punch_resp      = 1'b0;
            flags_in.punch_not_ready = !cmd.punch_online;
            if (!flags_ff.reader_resp) irq_in = 1'b0;
         end
         default: begin
            rsp.bad_function = 1'b1;
         end
      endcase
      rsp.interrupt_request = irq_in;
   end

endmodule

### design/paper_tape_reader_punch_controller.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                                         tuser
// req      in   write_word, modifier, tape_byte, tape_more,   mode
//               reader_online, punch_online
// rsp      out  read_data, status_word, punch_strobe,         -
//               punch_byte, tape_take, interrupt_request, bad_function
// csr      in   csr_we / csr_index / csr_wdata, one write per cycle
//
// One word per cycle sustained while rsp_tready is high; each word passes the input
// register, then the command logic writes the state and the result register.
// Synchronous active-high reset clears all flags, counters and valids; both
// wait registers return to 1000 ticks.
// A stalled rsp holds the pipeline; req_tready drops only when both stages are full.
module paper_tape_reader_punch_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] write_word, [16] modifier, [24:17] tape_byte, [25] tape_more,
   // [26] reader_online, [27] punch_online, [31:28] zero
   input  logic [31:0]                          req_tdata,
   // [3:0] mode
   input  logic [3:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] read_data, [31:16] status_word, [32] punch_strobe,
   // [40:33] punch_byte, [41] tape_take, [42] interrupt_request,
   // [43] bad_function, [47:44] zero
   output logic [47:0]                          rsp_tdata,
   input  logic                                 csr_we,
   input  logic [ptrpc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [ptrpc_pkg::WaitWidth-1:0]      csr_wdata
);

   ptrpc_pkg::cmd_type cmd_ff, cmd_in;
   ptrpc_pkg::rsp_type rsp_ff, rsp_in;
   logic               in_valid_ff;
   logic               out_valid_ff;
   logic               advance;
   logic               req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      cmd_in.mode          = req_tuser;
      cmd_in.write_word    = req_tdata[15:0];
      cmd_in.modifier      = req_tdata[16];
      cmd_in.tape_byte     = req_tdata[24:17];
      cmd_in.tape_more     = req_tdata[25];
      cmd_in.reader_online = req_tdata[26];
      cmd_in.punch_online  = req_tdata[27];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) cmd_ff <= cmd_in;
      if (advance) rsp_ff <= rsp_in;
   end

   ptrpc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .cmd       (cmd_ff),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_in)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_ff.bad_function, rsp_ff.interrupt_request,
                        rsp_ff.tape_take, rsp_ff.punch_byte, rsp_ff.punch_strobe,
                        rsp_ff.status_word, rsp_ff.read_data};

   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[43] |->
         rsp_tdata[32:0] == '0 && rsp_tdata[41:33] == '0)
      else $error("invalid command produced a side effect");

   a_take_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41] |-> rsp_tdata[31:0] == '0 && !rsp_tdata[32])
      else $error("tape take on a non-tick word");

   a_byte_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[40:33] == '0)
      else $error("punch byte without strobe");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(cmd_ff))
      else $error("input register lost a word");

endmodule
